>>> design/wia_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wia_pkg
// Types and constants shared by the 256-bit integer ALU.
// ----------------------------------------------------------------------------
package wia_pkg;

  localparam int unsigned WORD_W  = 256;
  localparam int unsigned LIMB_W  = 64;
  localparam int unsigned DIGIT_W = 32;
  localparam int unsigned DIGITS  = WORD_W / DIGIT_W;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_SHL = 2'd3;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [LIMB_W-1:0] a_limb0;
    logic [LIMB_W-1:0] a_limb1;
    logic [LIMB_W-1:0] a_limb2;
    logic [LIMB_W-1:0] a_limb3;
    logic [LIMB_W-1:0] b_limb0;
    logic [LIMB_W-1:0] b_limb1;
    logic [LIMB_W-1:0] b_limb2;
    logic [LIMB_W-1:0] b_limb3;
    logic [8:0]        shift_amount;
  } wia_in_t;

  typedef struct packed {
    logic [LIMB_W-1:0] r_limb0;
    logic [LIMB_W-1:0] r_limb1;
    logic [LIMB_W-1:0] r_limb2;
    logic [LIMB_W-1:0] r_limb3;
  } wia_out_t;

  // Data carried down the cell chain.
  typedef struct packed {
    logic              mul;
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] acc;
  } wia_pipe_t;

endpackage

>>> design/wide_int_alu_256.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wide_int_alu_256
// 256-bit unsigned add, subtract, low-half multiply and left shift.
// ----------------------------------------------------------------------------
// Accepts one item per cycle unless back-pressure from the output fills the
// chain, and returns one 256-bit result (mod 2^256) per item, in order. An
// entry stage computes add, subtract and shift directly, then eight cells
// each multiply one 32-bit digit of a by b (32x32 products, registered) and
// accumulate into a second register. Every stage has its own valid bit, so
// bubbles close up and new items keep entering while a finished result waits
// at the output, until the chain is full.
// ----------------------------------------------------------------------------
module wide_int_alu_256 (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  wia_pkg::wia_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output wia_pkg::wia_out_t out_data
);
  import wia_pkg::*;

  // Chain links: link k feeds cell k; link DIGITS is the output.
  logic      v   [DIGITS+1];
  logic      en  [DIGITS+1];
  wia_pipe_t pl  [DIGITS+1];

  wia_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .en_out   (en[0]),
    .vout     (v[0]),
    .pout     (pl[0])
  );

  for (genvar k = 0; k < DIGITS; k++) begin : g_cell
    wia_cell #(.Idx(k)) u_cell (
      .clk    (clk),
      .rst    (rst),
      .vin    (v[k]),
      .en_in  (en[k]),
      .pin    (pl[k]),
      .en_out (en[k+1]),
      .vout   (v[k+1]),
      .pout   (pl[k+1])
    );
  end

  assign en[DIGITS] = out_ready;
  assign out_valid  = v[DIGITS];

  assign out_data.r_limb0 = pl[DIGITS].acc[0*LIMB_W +: LIMB_W];
  assign out_data.r_limb1 = pl[DIGITS].acc[1*LIMB_W +: LIMB_W];
  assign out_data.r_limb2 = pl[DIGITS].acc[2*LIMB_W +: LIMB_W];
  assign out_data.r_limb3 = pl[DIGITS].acc[3*LIMB_W +: LIMB_W];

endmodule

>>> design/wia_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wia_front
// Entry stage: add, subtract and shift results, operand setup for multiply.
// ----------------------------------------------------------------------------
module wia_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  wia_pkg::wia_in_t  in_data,
  input  logic              en_out,
  output logic              vout,
  output wia_pkg::wia_pipe_t pout
);
  import wia_pkg::*;

  logic [WORD_W-1:0] a_w, b_w;
  wia_pipe_t         pipe_next;

  assign a_w = {in_data.a_limb3, in_data.a_limb2, in_data.a_limb1, in_data.a_limb0};
  assign b_w = {in_data.b_limb3, in_data.b_limb2, in_data.b_limb1, in_data.b_limb0};

  assign in_ready = !vout || en_out;

  always_comb begin
    pipe_next.a   = a_w;
    pipe_next.b   = b_w;
    pipe_next.mul = (in_data.req_type == OP_MUL);
    unique case (in_data.req_type)
      OP_ADD: pipe_next.acc = a_w + b_w;
      OP_SUB: pipe_next.acc = a_w + ~b_w + WORD_W'(1);
      OP_MUL: pipe_next.acc = '0;
      OP_SHL: pipe_next.acc = in_data.shift_amount[8] ? '0 : (a_w << in_data.shift_amount[7:0]);
      default: pipe_next.acc = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (in_ready) begin
      vout <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      pout <= pipe_next;
    end
  end

endmodule

>>> design/wia_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wia_cell
// One multiply cell: a 32-bit digit of a times b, then accumulate.
// ----------------------------------------------------------------------------
module wia_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               vin,
  output logic               en_in,
  input  wia_pkg::wia_pipe_t pin,
  input  logic               en_out,
  output logic               vout,
  output wia_pkg::wia_pipe_t pout
);
  import wia_pkg::*;

  // Even and odd digit products never overlap within their own group.
  logic [WORD_W+2*DIGIT_W-1:0] wide_e, wide_o;
  logic [2*DIGIT_W-1:0]        p;
  logic                        vp, en_a;
  wia_pipe_t                   p_pipe, a_pipe_next;
  logic [WORD_W-1:0]           prod_e, prod_o;

  always_comb begin
    wide_e = '0;
    wide_o = '0;
    p      = '0;
    for (int j = 0; j < DIGITS; j++) begin
      if (Idx + j < DIGITS) begin
        p = (2*DIGIT_W)'(pin.a[DIGIT_W*Idx +: DIGIT_W])
          * (2*DIGIT_W)'(pin.b[DIGIT_W*j +: DIGIT_W]);
        if (j % 2 == 0) wide_e[DIGIT_W*(Idx+j) +: 2*DIGIT_W] = p;
        else            wide_o[DIGIT_W*(Idx+j) +: 2*DIGIT_W] = p;
      end
    end
  end

  assign en_a  = !vout || en_out;
  assign en_in = !vp || en_a;

  always_comb begin
    a_pipe_next = p_pipe;
    if (p_pipe.mul) a_pipe_next.acc = p_pipe.acc + prod_e + prod_o;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp   <= 1'b0;
      vout <= 1'b0;
    end else begin
      if (en_in) vp   <= vin;
      if (en_a)  vout <= vp;
    end
  end

  always_ff @(posedge clk) begin
    if (en_in && vin) begin
      p_pipe <= pin;
      prod_e <= wide_e[WORD_W-1:0];
      prod_o <= wide_o[WORD_W-1:0];
    end
    if (en_a && vp) begin
      pout <= a_pipe_next;
    end
  end

  a_pass: assert property (@(posedge clk) disable iff (rst)
    en_a && vp && !p_pipe.mul |=> pout.acc == $past(p_pipe.acc))
    else $error("non-multiply accumulator changed in cell");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    vp && !en_a |=> vp && $stable(p_pipe))
    else $error("stalled product stage lost its item");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    vout && !en_out |=> vout && $stable(pout))
    else $error("stalled accumulate stage lost its item");

endmodule
